// ----- rtl/sacm_pkg.sv -----
// shared types and constants for the saturating audio channel mixer
package sacm_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int MAX_CHANNELS = 8;
    localparam int CHAN_SEL_W   = 3;
    localparam int START_LEN_W  = 24;
    localparam int BYTES_W      = SAMPLE_W * MAX_CHANNELS;
    localparam int IN_TDATA_W   = 104;
    localparam int OUT_TDATA_W  = 16;
    localparam int CONTRIB_W    = SAMPLE_W + 1;

    // sample bias and saturation ceiling
    localparam int SAMPLE_BIAS = 128;
    localparam int SAMPLE_MAX  = 255;

    typedef enum logic
    {
        OP_MIX   = 1'b0,
        OP_START = 1'b1
    } sacm_op_t;

    // per-item control broadcast to every lane
    typedef struct packed
    {
        logic                  mix;
        logic                  start;
        logic [CHAN_SEL_W-1:0] channel;
    } sacm_lane_ctrl_t;

endpackage

// ----- rtl/sacm_lane.sv -----
// one effect channel: length counter, active flag and unbiased contribution
module sacm_lane
#(
    parameter int LANE_IDX    = 0,
    parameter int LENGTH_BITS = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sacm_pkg::sacm_lane_ctrl_t ctrl,
    input  logic [7:0]               lane_byte,
    input  logic [LENGTH_BITS-1:0]   start_len,
    output logic                     take,
    output logic signed [8:0]        contrib
);
    import sacm_pkg::*;

    logic [LENGTH_BITS-1:0] remaining_reg;
    logic [LENGTH_BITS-1:0] remaining_next;
    logic                   active_reg;
    logic                   active_next;
    logic                   hit;

    assign hit  = ctrl.start && (ctrl.channel == CHAN_SEL_W'(LANE_IDX));
    assign take = active_reg && (remaining_reg != '0);

    always_comb
    begin
        if (take)
        begin
            contrib = $signed({1'b0, lane_byte}) - CONTRIB_W'(SAMPLE_BIAS);
        end
        else
        begin
            contrib = '0;
        end
    end

    always_comb
    begin
        remaining_next = remaining_reg;
        active_next    = active_reg;
        if (hit)
        begin
            remaining_next = start_len;
            active_next    = 1'b1;
        end
        else if (ctrl.mix && active_reg)
        begin
            if (take)
            begin
                remaining_next = remaining_reg - LENGTH_BITS'(1);
            end
            else
            begin
                // exhausted channel goes idle one sample after its last byte
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            active_reg    <= active_next;
        end
    end

endmodule

// ----- rtl/sacm_merge.sv -----
// adds lane contributions to the music sample, clamps, and buffers the result
module sacm_merge
#(
    parameter int CHANNELS = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [7:0]               music,
    input  logic signed [8:0]        contrib [CHANNELS],
    input  logic [CHANNELS-1:0]      take_mask,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [15:0]              out_data
);
    import sacm_pkg::*;

    localparam int SUM_W = CONTRIB_W + $clog2(CHANNELS + 1) + 1;

    logic signed [SUM_W-1:0] sum;
    logic [7:0]              mixed;
    logic [15:0]             new_data;
    logic                    pop;

    logic                    out_valid_reg;
    logic [15:0]             out_data_reg;
    logic                    skid_valid_reg;
    logic [15:0]             skid_data_reg;

    always_comb
    begin
        sum = SUM_W'($signed({1'b0, music})) - SUM_W'(SAMPLE_BIAS);
        for (int k = 0; k < CHANNELS; k++)
        begin
            sum = sum + SUM_W'(contrib[k]);
        end
        sum = sum + SUM_W'(SAMPLE_BIAS);
    end

    always_comb
    begin
        if (sum < 0)
        begin
            mixed = 8'h00;
        end
        else if (sum > SUM_W'(SAMPLE_MAX))
        begin
            mixed = 8'(SAMPLE_MAX);
        end
        else
        begin
            mixed = sum[7:0];
        end
    end

    assign new_data  = {8'(take_mask), mixed};
    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : new_data;
        end
        else if (push)
        begin
            skid_data_reg <= new_data;
        end
    end

endmodule

// ----- rtl/saturating_audio_channel_mixer_unit.sv -----
// top level of the saturating audio channel mixer
// an accepted mix item's result is registered onto the master side, or into the skid buffer if a result is stalled
// throughput: one item per cycle while tready is high; start items occupy a slot but give no result
// the output register plus a one-item skid buffer keep the slave side open
// while a result waits, so tready drops only when both hold an item
// reset (rst_n low, asynchronous): all channels idle, counts zero, buffers empty
module saturating_audio_channel_mixer_unit
#(
    parameter int CHANNELS    = 8,
    parameter int LENGTH_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // music_sample [7:0], channel_bytes [71:8], start_channel [74:72],
    // start_length [98:75], zero fill [103:99]
    input  logic [103:0] s_axis_tdata,
    // opcode: 0 mixes one sample, 1 starts a channel
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // mixed_sample [7:0], consumed_mask [15:8]
    output logic [15:0]  m_axis_tdata
);
    import sacm_pkg::*;

    logic                    accept;
    sacm_op_t                opcode;
    logic [7:0]              music_sample;
    logic [BYTES_W-1:0]      channel_bytes;
    logic [CHAN_SEL_W-1:0]   start_channel;
    logic [START_LEN_W-1:0]  start_length;
    logic [LENGTH_BITS-1:0]  len_sat;
    sacm_lane_ctrl_t         lane_ctrl;
    logic signed [8:0]       contrib [CHANNELS];
    logic [CHANNELS-1:0]     take_mask;

    // unpack the incoming item
    assign opcode        = sacm_op_t'(s_axis_tuser);
    assign music_sample  = s_axis_tdata[7:0];
    assign channel_bytes = s_axis_tdata[71:8];
    assign start_channel = s_axis_tdata[74:72];
    assign start_length  = s_axis_tdata[98:75];

    assign accept = s_axis_tvalid && s_axis_tready;

    // a length wider than the counter clamps to the counter's full scale
    always_comb
    begin
        if (LENGTH_BITS >= START_LEN_W)
        begin
            len_sat = LENGTH_BITS'(start_length);
        end
        else if ((start_length >> LENGTH_BITS) != '0)
        begin
            len_sat = '1;
        end
        else
        begin
            len_sat = LENGTH_BITS'(start_length);
        end
    end

    // one control word shared by all lanes; out-of-range channels match no lane
    assign lane_ctrl.mix     = accept && (opcode == OP_MIX);
    assign lane_ctrl.start   = accept && (opcode == OP_START);
    assign lane_ctrl.channel = start_channel;

    // one lane per effect channel, all evaluated in the same cycle
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        sacm_lane
        #(
            .LANE_IDX    (g),
            .LENGTH_BITS (LENGTH_BITS)
        )
        u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (lane_ctrl),
            .lane_byte (channel_bytes[8*g +: 8]),
            .start_len (len_sat),
            .take      (take_mask[g]),
            .contrib   (contrib[g])
        );
    end

    // sum, clamp and output buffering
    sacm_merge
    #(
        .CHANNELS (CHANNELS)
    )
    u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (lane_ctrl.mix),
        .music     (music_sample),
        .contrib   (contrib),
        .take_mask (take_mask),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- rtl/sacm_checker.sv -----
// port-level checks for the mixer and their binding to the top level
module sacm_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [15:0]  m_axis_tdata
);
    import sacm_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // back-pressure only arises with a result already pending
    a_ready_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // a mix item on an empty output shows up in the next cycle
    a_mix_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_MIX) && !m_axis_tvalid
        |=> m_axis_tvalid)
        else $error("mix item gave no result");

    // a start item on an empty output never produces a result
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_START) && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("start item produced a result");

endmodule

bind saturating_audio_channel_mixer_unit sacm_checker u_sacm_checker (.*);
